@@ hw/rtl/glc_pkg.sv @@
package glc_pkg;

  localparam int ID_W         = 64;
  localparam int STAMP_W      = 64;
  localparam int SLOT_W       = 4;
  localparam int GUARD_W      = 4;
  localparam int CAPACITY_DEF = 16;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [GUARD_W-1:0] GUARD_RESET = 4'd8;

  // request handed from the front queue to the lookup engine
  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] id;
  } glc_req_t;

endpackage

@@ hw/rtl/glc_ram.sv @@
module glc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

@@ hw/rtl/glc_front.sv @@
module glc_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [glc_pkg::ID_W-1:0] in_alloc_id,
  output glc_pkg::glc_req_t       req,
  input  logic                    req_ready
);

  import glc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [ID_W-1:0]  q_mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             push;
  logic             pop;

  assign in_stall = (count_r == CNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign pop      = req.valid && req_ready;

  assign req.valid = (count_r != '0);
  assign req.id    = q_mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= in_alloc_id;
    end
  end

endmodule

@@ hw/rtl/glc_back.sv @@
module glc_back #(
  parameter int CAPACITY = glc_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  glc_pkg::glc_req_t           req,
  output logic                        req_ready,
  input  logic [glc_pkg::GUARD_W-1:0] guard,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_hit,
  output logic [glc_pkg::SLOT_W-1:0]  out_slot,
  output logic                        out_evicted,
  output logic [glc_pkg::ID_W-1:0]    out_evicted_id
);

  import glc_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_t;

  state_t               state_r;
  logic [CAPACITY-1:0]  valid_r;
  logic [STAMP_W-1:0]   use_cnt_r;
  logic [STAMP_W-1:0]   use_cnt_nxt;
  logic [STAMP_W-1:0]   thresh_r;
  logic                 thresh_ok_r;
  logic [ID_W-1:0]      id_r;

  logic [CNT_W-1:0]     rd_cnt_r;
  logic                 p_vld_r;
  logic [IDX_W-1:0]     p_idx_r;

  logic                 hit_r;
  logic [IDX_W-1:0]     hit_idx_r;
  logic                 free_found_r;
  logic [IDX_W-1:0]     free_idx_r;
  logic                 u_found_r;
  logic [IDX_W-1:0]     u_idx_r;
  logic [STAMP_W-1:0]   u_stamp_r;
  logic [ID_W-1:0]      u_key_r;
  logic                 a_found_r;
  logic [IDX_W-1:0]     a_idx_r;
  logic [STAMP_W-1:0]   a_stamp_r;
  logic [ID_W-1:0]      a_key_r;

  logic                 out_valid_r;
  logic                 out_hit_r;
  logic [SLOT_W-1:0]    out_slot_r;
  logic                 out_evicted_r;
  logic [ID_W-1:0]      out_evicted_id_r;

  logic [ID_W-1:0]      key_rd;
  logic [STAMP_W-1:0]   stamp_rd;
  logic                 issue;
  logic [IDX_W-1:0]     raddr;
  logic                 entry_v;
  logic                 match;
  logic                 unprot;
  logic                 last;
  logic [STAMP_W:0]     sub;
  logic                 out_free;
  logic                 commit;
  logic                 evict;
  logic [IDX_W-1:0]     fin_idx;
  logic [SLOT_W+IDX_W-1:0] slot_ext;

  assign req_ready = (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign commit    = (state_r == ST_FIN) && out_free;

  assign issue = (state_r == ST_SCAN) && (rd_cnt_r < CNT_W'(CAPACITY));
  assign raddr = rd_cnt_r[IDX_W-1:0];

  assign entry_v = valid_r[p_idx_r];
  assign match   = p_vld_r && entry_v && (key_rd == id_r);
  assign unprot  = thresh_ok_r && (stamp_rd <= thresh_r);
  assign last    = (p_idx_r == IDX_W'(CAPACITY - 1));

  // counter minus guard, borrow means nothing is old enough
  assign sub = {1'b0, use_cnt_r} - {(STAMP_W + 1 - GUARD_W)'(0), guard};

  assign use_cnt_nxt = use_cnt_r + STAMP_W'(1);
  assign evict       = !hit_r && !free_found_r;

  always_comb begin
    if (hit_r) begin
      fin_idx = hit_idx_r;
    end else if (free_found_r) begin
      fin_idx = free_idx_r;
    end else if (u_found_r) begin
      fin_idx = u_idx_r;
    end else begin
      fin_idx = a_idx_r;
    end
  end

  assign slot_ext = {SLOT_W'(0), fin_idx};

  glc_ram #(
    .WIDTH (ID_W),
    .DEPTH (CAPACITY)
  ) u_key_ram (
    .clk   (clk),
    .we    (commit && !hit_r),
    .waddr (fin_idx),
    .wdata (id_r),
    .raddr (raddr),
    .rdata (key_rd)
  );

  glc_ram #(
    .WIDTH (STAMP_W),
    .DEPTH (CAPACITY)
  ) u_stamp_ram (
    .clk   (clk),
    .we    (commit),
    .waddr (fin_idx),
    .wdata (use_cnt_nxt),
    .raddr (raddr),
    .rdata (stamp_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      use_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      p_vld_r     <= 1'b0;
    end else begin
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (req.valid) begin
            id_r         <= req.id;
            thresh_r     <= sub[STAMP_W-1:0];
            thresh_ok_r  <= !sub[STAMP_W];
            rd_cnt_r     <= '0;
            p_vld_r      <= 1'b0;
            hit_r        <= 1'b0;
            free_found_r <= 1'b0;
            u_found_r    <= 1'b0;
            a_found_r    <= 1'b0;
            state_r      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          p_vld_r <= issue;
          p_idx_r <= raddr;
          if (issue) begin
            rd_cnt_r <= rd_cnt_r + CNT_W'(1);
          end
          if (p_vld_r) begin
            if (match) begin
              hit_r     <= 1'b1;
              hit_idx_r <= p_idx_r;
              state_r   <= ST_FIN;
            end else begin
              if (!entry_v && !free_found_r) begin
                free_found_r <= 1'b1;
                free_idx_r   <= p_idx_r;
              end
              // strict compare keeps the lowest slot on ties
              if (entry_v && unprot && (!u_found_r || stamp_rd < u_stamp_r)) begin
                u_found_r <= 1'b1;
                u_idx_r   <= p_idx_r;
                u_stamp_r <= stamp_rd;
                u_key_r   <= key_rd;
              end
              if (entry_v && (!a_found_r || stamp_rd < a_stamp_r)) begin
                a_found_r <= 1'b1;
                a_idx_r   <= p_idx_r;
                a_stamp_r <= stamp_rd;
                a_key_r   <= key_rd;
              end
              if (last) begin
                state_r <= ST_FIN;
              end
            end
          end
        end
        ST_FIN: begin
          p_vld_r <= 1'b0;
          if (out_free) begin
            use_cnt_r          <= use_cnt_nxt;
            valid_r[fin_idx]   <= 1'b1;
            out_hit_r          <= hit_r;
            out_slot_r         <= slot_ext[SLOT_W-1:0];
            out_evicted_r      <= evict;
            if (!evict) begin
              out_evicted_id_r <= '0;
            end else if (u_found_r) begin
              out_evicted_id_r <= u_key_r;
            end else begin
              out_evicted_id_r <= a_key_r;
            end
            state_r            <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_slot       = out_slot_r;
  assign out_evicted    = out_evicted_r;
  assign out_evicted_id = out_evicted_id_r;

endmodule

@@ hw/rtl/guarded_lru_import_cache.sv @@
// Fully associative cache of CAPACITY entries keyed by a 64-bit allocation id, with a
// recency guard that shields recently used entries from eviction unless every valid
// entry is inside the guard. Each item gives one result: hit flag, slot, and the
// evicted id on a miss into a full cache. Keys and stamps sit in two small RAMs that
// the lookup engine scans one entry per cycle. A two-item input queue keeps taking
// items while the engine works until it is full, and the output register holds a
// finished result while the next item is looked up. The guard is written through
// the cfg port (always ready) and may only be changed while the block is idle.
module guarded_lru_import_cache #(
  parameter int CAPACITY = glc_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [glc_pkg::ID_W-1:0]    in_alloc_id,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_hit,
  output logic [glc_pkg::SLOT_W-1:0]  out_slot,
  output logic                        out_evicted,
  output logic [glc_pkg::ID_W-1:0]    out_evicted_id,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [glc_pkg::GUARD_W-1:0] cfg_recency_guard
);

  import glc_pkg::*;

  logic [GUARD_W-1:0] guard_r;
  glc_req_t           req;
  logic               req_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      guard_r <= GUARD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      guard_r <= cfg_recency_guard;
    end
  end

  glc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_alloc_id (in_alloc_id),
    .req         (req),
    .req_ready   (req_ready)
  );

  glc_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .req            (req),
    .req_ready      (req_ready),
    .guard          (guard_r),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_slot       (out_slot),
    .out_evicted    (out_evicted),
    .out_evicted_id (out_evicted_id)
  );

endmodule
